### rtl/otst_pkg.sv
// Shared types and constants for the operand type stack tracker.
// No dependencies; imported by the rule unit and the top level.
package otst_pkg;

    typedef logic [4:0] type_code_t;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_PUSH  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_ARITH = 3'd3;
    localparam logic [2:0] OP_CMP   = 3'd4;
    localparam logic [2:0] OP_SHIFT = 3'd5;
    localparam logic [2:0] OP_UNARY = 3'd6;
    localparam logic [2:0] OP_DUP   = 3'd7;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNDER = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_NORES = 2'd3;

    localparam type_code_t T_I32    = 5'd2;
    localparam type_code_t T_I64    = 5'd3;
    localparam type_code_t T_U64    = 5'd7;
    localparam type_code_t T_NINT   = 5'd8;
    localparam type_code_t T_NUINT  = 5'd9;
    localparam type_code_t T_FLOAT  = 5'd10;
    localparam type_code_t T_F64    = 5'd12;
    localparam type_code_t T_PTR    = 5'd13;
    localparam type_code_t T_VEC_LO = 5'd15;
    localparam type_code_t T_VEC_HI = 5'd26;

    typedef struct packed {
        logic [2:0] operation;
        logic [4:0] pop_count;
        type_code_t given_type;
    } op_word_t;

    typedef struct packed {
        logic [6:0] depth;
        type_code_t top_type;
        logic       top_valid;
        logic [1:0] status;
    } res_word_t;

endpackage

### rtl/otst_type_rules.sv
// Result type rules for binary arithmetic, compare, shift and unary words.
// Depends on otst_pkg for type codes and operation codes.
module otst_type_rules
    import otst_pkg::*;
(
    input  logic [2:0] operation,
    input  type_code_t below,
    input  type_code_t top,
    output type_code_t result_type,
    output logic       no_result
);

    function automatic logic is_small_int(input type_code_t t);
        is_small_int = (t == 5'd0) || (t == 5'd1) || (t == 5'd2) ||
                       (t == 5'd4) || (t == 5'd5) || (t == 5'd6);
    endfunction

    function automatic logic is_long_int(input type_code_t t);
        is_long_int = (t == T_I64) || (t == T_U64);
    endfunction

    function automatic logic is_native(input type_code_t t);
        is_native = (t == T_NINT) || (t == T_NUINT);
    endfunction

    function automatic logic is_float(input type_code_t t);
        is_float = (t >= T_FLOAT) && (t <= T_F64);
    endfunction

    function automatic logic is_vector(input type_code_t t);
        is_vector = (t >= T_VEC_LO) && (t <= T_VEC_HI);
    endfunction

    always_comb
    begin
        result_type = T_I32;
        no_result   = 1'b0;
        case (operation)
            OP_ARITH:
            begin
                priority if (is_small_int(below))
                begin
                    priority if (is_small_int(top))
                        result_type = T_I32;
                    else if (is_native(top))
                        result_type = T_NINT;
                    else if (top == T_PTR)
                        result_type = T_PTR;
                    else
                        no_result = 1'b1;
                end
                else if (is_long_int(below))
                    result_type = T_I64;
                else if (is_native(below))
                    result_type = (top == T_PTR) ? T_PTR : T_NINT;
                else if (is_float(below))
                    result_type = T_FLOAT;
                else if (below == T_PTR)
                    result_type = (top == T_PTR) ? T_NINT : T_PTR;
                else if (is_vector(below) && (below == top))
                    result_type = below;
                else
                    no_result = 1'b1;
            end
            OP_SHIFT:
            begin
                priority if (is_small_int(below))
                    result_type = T_I32;
                else if (is_long_int(below))
                    result_type = T_I64;
                else
                    result_type = T_NINT;
            end
            OP_UNARY:
            begin
                priority if (is_small_int(top))
                    result_type = T_I32;
                else if (is_long_int(top))
                    result_type = T_I64;
                else if (is_float(top))
                    result_type = T_FLOAT;
                else if (is_native(top))
                    result_type = T_NINT;
                else
                    no_result = 1'b1;
            end
            default:
                result_type = T_I32;
        endcase
    end

endmodule

### rtl/operand_type_stack_tracker_unit.sv
// Operand type stack tracker: type stack in one synchronous memory, top entry in a register.
// The result word is registered as S_EXEC ends; S_EXEC waits while a result word is stalled.
// A word is accepted only in S_IDLE: the accept edge reads the entry the word needs (the new top
// after a pop, else the one below the top); S_EXEC writes back through the single write port.
// Reset clears depth, state and the result valid; the memory and the top entry are not cleared.
// Depends on otst_pkg and otst_type_rules.
module operand_type_stack_tracker_unit
    import otst_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_stall,
    input  op_word_t  op,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int EW = ((DW > 5) ? DW : 5) + 1;
    localparam logic [EW-1:0] SD_EXT = EW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    op_word_t        item_reg;
    logic [DW-1:0]   depth_reg, depth_next;
    type_code_t      top_reg, top_next;
    res_word_t       res_reg, res_next;
    logic            res_valid_reg, res_valid_next;

    type_code_t      mem [STACK_DEPTH];
    type_code_t      rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    type_code_t      wr_data;
    logic            wr_en;

    logic            accept;
    logic            exec_go;
    logic [EW-1:0]   d_ext, cnt_ext, remain_ext, idx_top, idx_below, rd_ext;
    logic [1:0]      status;
    type_code_t      rule_type;
    logic            rule_nores;

    assign op_stall  = (state_reg != S_IDLE);
    assign accept    = op_valid && !op_stall;
    assign exec_go   = (state_reg == S_EXEC) && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign d_ext      = EW'(depth_reg);
    assign cnt_ext    = EW'(item_reg.pop_count);
    assign remain_ext = d_ext - cnt_ext;
    assign idx_top    = d_ext - EW'(1);
    assign idx_below  = d_ext - EW'(2);

    // pick the entry the word will need: new top after a pop, else the one below the top
    assign rd_ext  = (op.operation == OP_POP) ? (d_ext - EW'(op.pop_count) - EW'(1))
                                              : (d_ext - EW'(2));
    assign rd_addr = rd_ext[AW-1:0];

    otst_type_rules u_rules (
        .operation   (item_reg.operation),
        .below       (rd_data_reg),
        .top         (top_reg),
        .result_type (rule_type),
        .no_result   (rule_nores)
    );

    always_comb
    begin
        depth_next = depth_reg;
        top_next   = top_reg;
        status     = STAT_OK;
        wr_en      = 1'b0;
        wr_addr    = idx_top[AW-1:0];
        wr_data    = rule_type;
        unique case (item_reg.operation)
            OP_NONE:
            begin
                status = STAT_OK;
            end
            OP_PUSH:
            begin
                priority if (cnt_ext > d_ext)
                    status = STAT_UNDER;
                else if (remain_ext == SD_EXT)
                    status = STAT_OVER;
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = remain_ext[AW-1:0];
                    wr_data    = item_reg.given_type;
                    depth_next = DW'(remain_ext + EW'(1));
                    top_next   = item_reg.given_type;
                end
            end
            OP_POP:
            begin
                if (cnt_ext > d_ext)
                    status = STAT_UNDER;
                else
                begin
                    depth_next = DW'(remain_ext);
                    top_next   = rd_data_reg;
                end
            end
            OP_ARITH, OP_CMP, OP_SHIFT:
            begin
                priority if (d_ext < EW'(2))
                    status = STAT_UNDER;
                else if (rule_nores)
                    status = STAT_NORES;
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_below[AW-1:0];
                    depth_next = DW'(idx_top);
                    top_next   = rule_type;
                end
            end
            OP_UNARY:
            begin
                priority if (d_ext == '0)
                    status = STAT_UNDER;
                else if (rule_nores)
                    status = STAT_NORES;
                else
                begin
                    wr_en    = 1'b1;
                    top_next = rule_type;
                end
            end
            OP_DUP:
            begin
                priority if (d_ext == '0)
                    status = STAT_UNDER;
                else if (d_ext >= SD_EXT)
                    status = STAT_OVER;
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = d_ext[AW-1:0];
                    wr_data    = top_reg;
                    depth_next = DW'(d_ext + EW'(1));
                end
            end
        endcase
    end

    always_comb
    begin
        res_next.depth     = 7'(depth_next);
        res_next.top_valid = (depth_next != '0);
        res_next.top_type  = (depth_next != '0) ? top_next : '0;
        res_next.status    = status;
    end

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // hold while the previous result word is still stalled
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (exec_go)
                depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= op;
        if (exec_go)
        begin
            top_reg <= top_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && wr_en)
            mem[wr_addr] <= wr_data;
        if (accept)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

### tb/sv/tb_operand_type_stack_tracker_unit.sv
// Self-checking testbench for operand_type_stack_tracker_unit: drives decoded
// instruction words and checks every result word against a local type-stack model.
// Depends on otst_pkg and the RTL of the unit.
module tb_operand_type_stack_tracker_unit;
    import otst_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    // Type codes with no name in the package
    localparam type_code_t T_I8       = 5'd0;
    localparam type_code_t T_I16      = 5'd1;
    localparam type_code_t T_U8       = 5'd4;
    localparam type_code_t T_U16      = 5'd5;
    localparam type_code_t T_U32      = 5'd6;
    localparam type_code_t T_F32      = 5'd11;
    localparam type_code_t T_VALUE    = 5'd14;
    localparam type_code_t T_CODE_MAX = 5'd31;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      op_valid = 1'b0;
    logic      op_stall;
    op_word_t  op = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res;

    op_word_t   word_backlog[$];
    res_word_t  expected_results[$];
    type_code_t type_mem[STACK_DEPTH];
    int         type_level = 0;
    logic       op_taken = 1'b0;
    int         idle_pct = 15;
    int         fail_count = 0;
    int         words_made = 0;
    int         cycle_count = 0;

    operand_type_stack_tracker_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op        (op),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #5 clk = ~clk;

    function automatic logic is_small_int(type_code_t t);
        return t == T_I8 || t == T_I16 || t == T_I32 || t == T_U8 || t == T_U16 || t == T_U32;
    endfunction

    function automatic logic is_long_int(type_code_t t);
        return t == T_I64 || t == T_U64;
    endfunction

    function automatic logic is_native(type_code_t t);
        return t == T_NINT || t == T_NUINT;
    endfunction

    function automatic logic is_float(type_code_t t);
        return t >= T_FLOAT && t <= T_F64;
    endfunction

    // Apply one instruction word to the local stack and queue its result word.
    task automatic track_word(input op_word_t w);
        type_code_t below;
        type_code_t top;
        type_code_t r;
        logic [1:0] st;
        logic       ok;
        int         d;
        int         cnt;
        res_word_t  e;
        d = type_level;
        cnt = int'(w.pop_count);
        st = STAT_OK;
        ok = 1'b1;
        r = '0;
        below = (d >= 2) ? type_mem[d - 2] : '0;
        top = (d >= 1) ? type_mem[d - 1] : '0;
        case (w.operation)
            OP_PUSH:
                if (cnt > d) st = STAT_UNDER;
                else if (d - cnt + 1 > STACK_DEPTH) st = STAT_OVER;
                else
                begin
                    d = d - cnt;
                    type_mem[d] = w.given_type;
                    d = d + 1;
                end
            OP_POP:
                if (cnt > d) st = STAT_UNDER;
                else d = d - cnt;
            OP_ARITH, OP_CMP, OP_SHIFT:
                if (d < 2) st = STAT_UNDER;
                else
                begin
                    if (w.operation == OP_ARITH)
                    begin
                        if (is_small_int(below))
                        begin
                            if (is_small_int(top)) r = T_I32;
                            else if (is_native(top)) r = T_NINT;
                            else if (top == T_PTR) r = T_PTR;
                            else ok = 1'b0;
                        end
                        else if (is_long_int(below)) r = T_I64;
                        else if (is_native(below)) r = (top == T_PTR) ? T_PTR : T_NINT;
                        else if (is_float(below)) r = T_FLOAT;
                        else if (below == T_PTR) r = (top == T_PTR) ? T_NINT : T_PTR;
                        else if (below >= T_VEC_LO && below <= T_VEC_HI && below == top)
                            r = below;
                        else ok = 1'b0;
                    end
                    else if (w.operation == OP_CMP) r = T_I32;
                    else r = is_small_int(below) ? T_I32 : (is_long_int(below) ? T_I64 : T_NINT);
                    if (ok)
                    begin
                        type_mem[d - 2] = r;
                        d = d - 1;
                    end
                    else st = STAT_NORES;
                end
            OP_UNARY:
                if (d < 1) st = STAT_UNDER;
                else
                begin
                    if (is_small_int(top)) r = T_I32;
                    else if (is_long_int(top)) r = T_I64;
                    else if (is_float(top)) r = T_FLOAT;
                    else if (is_native(top)) r = T_NINT;
                    else ok = 1'b0;
                    if (ok) type_mem[d - 1] = r;
                    else st = STAT_NORES;
                end
            OP_DUP:
                if (d < 1) st = STAT_UNDER;
                else if (d >= STACK_DEPTH) st = STAT_OVER;
                else
                begin
                    type_mem[d] = type_mem[d - 1];
                    d = d + 1;
                end
            default: ;
        endcase
        type_level = d;
        e.depth = d[6:0];
        e.top_type = (d > 0) ? type_mem[d - 1] : '0;
        e.top_valid = (d > 0);
        e.status = st;
        expected_results.push_back(e);
    endtask

    // Sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    res_word_t e;
                    e = expected_results.pop_front();
                    if (res.depth !== e.depth)
                    begin
                        $error("depth: expected %0d, got %0d", e.depth, res.depth);
                        fail_count++;
                    end
                    if (res.top_type !== e.top_type)
                    begin
                        $error("top_type: expected %0d, got %0d", e.top_type, res.top_type);
                        fail_count++;
                    end
                    if (res.top_valid !== e.top_valid)
                    begin
                        $error("top_valid: expected %0d, got %0d", e.top_valid, res.top_valid);
                        fail_count++;
                    end
                    if (res.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, res.status);
                        fail_count++;
                    end
                end
            end
            if (op_valid && !op_stall)
                track_word(op);
            op_taken <= op_valid && !op_stall;
        end
    end

    // Hold a stalled word; otherwise advance or idle.
    always @(negedge clk)
    begin
        if (rst_n && (!op_valid || op_taken))
        begin
            if (word_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                op <= word_backlog.pop_front();
                op_valid <= 1'b1;
            end
            else
                op_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic post_word(input logic [2:0] operation, input int cnt, input int ty);
        op_word_t w;
        w.operation = operation;
        w.pop_count = cnt[4:0];
        w.given_type = ty[4:0];
        word_backlog.push_back(w);
        words_made++;
    endtask

    function automatic type_code_t pick_type();
        case ($urandom_range(0, 9))
            0: return T_PTR;
            1: return type_code_t'($urandom_range(27, 31));
            2, 3: return type_code_t'($urandom_range(T_VEC_LO, T_VEC_HI));
            default: return type_code_t'($urandom_range(0, 26));
        endcase
    endfunction

    task automatic wait_drained();
        while (word_backlog.size() != 0 || op_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed expression sequences, with fills, drains and noise mixed in.
    task automatic make_random(input int count);
        int target;
        int r;
        int n;
        type_code_t a;
        type_code_t b;
        target = words_made + count;
        while (words_made < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                a = pick_type();
                b = ($urandom_range(0, 3) == 0) ? a : pick_type();
                post_word(OP_PUSH, 0, a);
                post_word(OP_PUSH, 0, b);
                case ($urandom_range(0, 3))
                    0: post_word(OP_ARITH, $urandom_range(0, 31), $urandom_range(0, 31));
                    1: post_word(OP_CMP, $urandom_range(0, 31), $urandom_range(0, 31));
                    2: post_word(OP_SHIFT, $urandom_range(0, 31), $urandom_range(0, 31));
                    default: post_word(OP_PUSH, 2, pick_type());
                endcase
                if ($urandom_range(0, 2) == 0)
                    post_word(OP_UNARY, $urandom_range(0, 31), $urandom_range(0, 31));
                post_word(OP_POP, 1, $urandom_range(0, 31));
            end
            else if (r < 70)
                post_word(OP_PUSH, $urandom_range(0, 4), pick_type());
            else if (r < 85)
                post_word(3'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom_range(0, 31));
            else if (r < 88)
            begin
                // fill to the top, then probe the full stack
                for (n = 0; n < 66; n++)
                begin
                    if ($urandom_range(0, 9) < 7)
                        post_word(OP_PUSH, 0, pick_type());
                    else
                        post_word(OP_DUP, $urandom_range(0, 31), $urandom_range(0, 31));
                end
                post_word(OP_PUSH, 0, pick_type());
                post_word(OP_PUSH, 1, pick_type());
                post_word(OP_DUP, $urandom_range(0, 31), $urandom_range(0, 31));
            end
            else if (r < 93)
            begin
                for (n = 0; n < 3; n++)
                    post_word(OP_POP, 31, $urandom_range(0, 31));
                post_word(OP_POP, $urandom_range(0, 2), $urandom_range(0, 31));
                post_word(OP_PUSH, $urandom_range(1, 31), pick_type());
            end
            else
            begin
                post_word(OP_UNARY, $urandom_range(0, 31), $urandom_range(0, 31));
                post_word(OP_DUP, $urandom_range(0, 31), $urandom_range(0, 31));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-stack underflows, odd types, vectors, full pops
        post_word(OP_NONE, 0, 0);
        post_word(OP_POP, 1, 0);
        post_word(OP_ARITH, 0, 0);
        post_word(OP_UNARY, 0, 0);
        post_word(OP_DUP, 0, 0);
        post_word(OP_PUSH, 1, T_I32);
        post_word(OP_PUSH, 0, T_CODE_MAX);
        post_word(OP_UNARY, 0, 0);
        post_word(OP_DUP, 0, 0);
        post_word(OP_ARITH, 0, 0);
        post_word(OP_CMP, 0, 0);
        post_word(OP_PUSH, 0, T_PTR);
        post_word(OP_SHIFT, 0, 0);
        post_word(OP_PUSH, 0, T_VEC_HI);
        post_word(OP_PUSH, 0, T_VEC_HI);
        post_word(OP_ARITH, 0, 0);
        post_word(OP_PUSH, 0, T_VEC_LO);
        post_word(OP_ARITH, 0, 0);
        post_word(OP_POP, 31, 0);
        post_word(OP_POP, 3, 0);
        post_word(OP_PUSH, 0, T_I8);
        post_word(OP_PUSH, 0, T_PTR);
        post_word(OP_ARITH, 0, 0);
        post_word(OP_UNARY, 0, 0);
        post_word(OP_PUSH, 1, T_F64);
        post_word(OP_UNARY, 0, 0);
        post_word(OP_PUSH, 0, T_NUINT);
        post_word(OP_ARITH, 0, 0);
        post_word(OP_PUSH, 0, T_VALUE);
        post_word(OP_ARITH, 0, 0);
        post_word(OP_NONE, 31, T_CODE_MAX);
        // hold the sender until the directed words have all come back
        wait_drained();

        make_random(400);
        wait_drained();
        idle_pct = 0;
        make_random(150);
        wait_drained();
        idle_pct = 15;
        make_random(400);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
